// ===== rtl/core/rounded_border_span_generator_macros.svh =====
// Assertion macros used by the checker file rbsg_checker.sv.
`ifndef ROUNDED_BORDER_SPAN_GENERATOR_MACROS_SVH
`define ROUNDED_BORDER_SPAN_GENERATOR_MACROS_SVH

// Same-cycle implication.
`define RBSG_ASSERT_IMPL(lbl, clk, dis, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RBSG_ASSERT_NEXT(lbl, clk, dis, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/rbsg_pkg.sv =====
package rbsg_pkg;

   localparam int RADIUS_CAP = 15;
   localparam int R_W        = $clog2(RADIUS_CAP + 1);
   localparam int ROOT_W     = R_W + 1;
   localparam int SQ_W       = 2 * ROOT_W;

   localparam int COORD_W = 16;
   localparam int SIZE_W  = 14;
   localparam int BYTE_W  = 8;
   localparam int COL_W   = 4 * BYTE_W;
   localparam int LEFT_W  = 17;
   localparam int RW_W    = 15;
   localparam int EXT_W   = LEFT_W + 1;

   localparam int REQ_W = 112;
   localparam int RSP_W = 96;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLAMP,
      ST_EDGE,
      ST_ROW_A,
      ST_WAIT_A,
      ST_ROW_B,
      ST_WAIT_B,
      ST_SPAN,
      ST_EMIT,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic load;
      logic clamp;
      logic part_clr;
      logic part_inc;
      logic row_clr;
      logic row_inc;
      logic sqrt_start;
      logic sqrt_sel_b;
      logic latch_a;
      logic latch_b;
      logic span_calc;
      logic push;
      logic push_span;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic degenerate;
      logic r_zero;
      logic part_last;
      logic edge_on;
      logic row_last;
      logic span_empty;
      logic sqrt_busy;
      logic push_ok;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/core/rbsg_isqrt.sv =====
module rbsg_isqrt (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [rbsg_pkg::SQ_W-1:0]      value,
   output logic                           busy,
   output logic [rbsg_pkg::ROOT_W-1:0]    root,
   output logic                           exact
);

   localparam logic [rbsg_pkg::SQ_W-1:0] BIT_TOP = {2'b01, {(rbsg_pkg::SQ_W-2){1'b0}}};

   logic [rbsg_pkg::SQ_W-1:0] rem_ff, rem_in;
   logic [rbsg_pkg::SQ_W-1:0] res_ff, res_in;
   logic [rbsg_pkg::SQ_W-1:0] bit_ff, bit_in;
   logic                      busy_ff, busy_in;
   logic [rbsg_pkg::SQ_W:0]   trial;

   assign trial = {1'b0, res_ff} + {1'b0, bit_ff};

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = value;
         res_in  = '0;
         bit_in  = BIT_TOP;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in = rem_ff - trial[rbsg_pkg::SQ_W-1:0];
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         busy_in = |bit_ff[rbsg_pkg::SQ_W-1:2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign busy  = busy_ff;
   assign root  = res_ff[rbsg_pkg::ROOT_W-1:0];
   assign exact = (rem_ff == '0);

endmodule

// ===== rtl/core/rbsg_ctrl.sv =====
module rbsg_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  rbsg_pkg::status_type   status,
   output rbsg_pkg::cmd_type      cmd
);

   rbsg_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rbsg_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         rbsg_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = rbsg_pkg::ST_CLAMP;
            end
         end
         rbsg_pkg::ST_CLAMP: begin
            if (status.degenerate) begin
               state_in = rbsg_pkg::ST_IDLE;
            end else begin
               cmd.clamp    = 1'b1;
               cmd.part_clr = 1'b1;
               state_in     = rbsg_pkg::ST_EDGE;
            end
         end
         rbsg_pkg::ST_EDGE: begin
            if (!status.edge_on || status.push_ok) begin
               cmd.push     = status.edge_on;
               cmd.part_inc = 1'b1;
               if (status.part_last) begin
                  if (status.r_zero) begin
                     state_in = rbsg_pkg::ST_FLUSH;
                  end else begin
                     cmd.row_clr = 1'b1;
                     state_in    = rbsg_pkg::ST_ROW_A;
                  end
               end
            end
         end
         rbsg_pkg::ST_ROW_A: begin
            cmd.sqrt_start = 1'b1;
            state_in       = rbsg_pkg::ST_WAIT_A;
         end
         rbsg_pkg::ST_WAIT_A: begin
            if (!status.sqrt_busy) begin
               cmd.latch_a = 1'b1;
               state_in    = rbsg_pkg::ST_ROW_B;
            end
         end
         rbsg_pkg::ST_ROW_B: begin
            cmd.sqrt_start = 1'b1;
            cmd.sqrt_sel_b = 1'b1;
            state_in       = rbsg_pkg::ST_WAIT_B;
         end
         rbsg_pkg::ST_WAIT_B: begin
            if (!status.sqrt_busy) begin
               cmd.latch_b = 1'b1;
               state_in    = rbsg_pkg::ST_SPAN;
            end
         end
         rbsg_pkg::ST_SPAN: begin
            cmd.span_calc = 1'b1;
            cmd.part_clr  = 1'b1;
            state_in      = rbsg_pkg::ST_EMIT;
         end
         rbsg_pkg::ST_EMIT: begin
            if (status.span_empty || (status.push_ok && status.part_last)) begin
               if (!status.span_empty) begin
                  cmd.push      = 1'b1;
                  cmd.push_span = 1'b1;
                  cmd.part_inc  = 1'b1;
               end
               if (status.row_last) begin
                  state_in = rbsg_pkg::ST_FLUSH;
               end else begin
                  cmd.row_inc = 1'b1;
                  state_in    = rbsg_pkg::ST_ROW_A;
               end
            end else if (status.push_ok) begin
               cmd.push      = 1'b1;
               cmd.push_span = 1'b1;
               cmd.part_inc  = 1'b1;
            end
         end
         rbsg_pkg::ST_FLUSH: begin
            if (status.out_free) begin
               cmd.flush = 1'b1;
               state_in  = rbsg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rbsg_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/rbsg_dp.sv =====
module rbsg_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  rbsg_pkg::cmd_type             cmd,
   output rbsg_pkg::status_type          status,
   input  logic [rbsg_pkg::REQ_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [rbsg_pkg::RSP_W-1:0]    rsp_tdata,
   output logic                          rsp_tlast
);

   localparam int R_W    = rbsg_pkg::R_W;
   localparam int ROOT_W = rbsg_pkg::ROOT_W;
   localparam int SQ_W   = rbsg_pkg::SQ_W;
   localparam int SIZE_W = rbsg_pkg::SIZE_W;
   localparam int BYTE_W = rbsg_pkg::BYTE_W;
   localparam int EXT_W  = rbsg_pkg::EXT_W;

   // box registers
   logic [rbsg_pkg::COORD_W-1:0] x_ff, y_ff;
   logic [SIZE_W-1:0]            w_ff, h_ff;
   logic [BYTE_W-1:0]            t_ff, rq_ff;
   logic [rbsg_pkg::COL_W-1:0]   col_ff;
   logic [R_W-1:0]               r_ff, r_in;
   logic [1:0]                   part_ff;
   logic [R_W-1:0]               row_ff;
   logic [ROOT_W-1:0]            ca_ff, fb_ff;
   logic [R_W-1:0]               ss_ff, se_ff, sw_ff;

   // output word and one-deep hold so the final word can carry tlast
   logic                         out_valid_ff, out_valid_in;
   logic [rbsg_pkg::RSP_W-1:0]   out_data_ff, out_data_in;
   logic                         out_last_ff, out_last_in;
   logic                         hold_valid_ff, hold_valid_in;
   logic [rbsg_pkg::RSP_W-1:0]   hold_data_ff, hold_data_in;

   logic [SIZE_W-1:0]   half_c, rlim_c;
   logic [R_W-1:0]      ri_c;
   logic [ROOT_W-1:0]   dr_c, d_c, dri_c;
   logic                b_ok;
   logic [SQ_W-1:0]     r2_c, d2_c, i2_c, sq_val;
   logic                sq_busy, sq_exact;
   logic [ROOT_W-1:0]   sq_root;
   logic [ROOT_W:0]     ca_sum, ss_c, se_c, rx_c;
   logic                out_free;

   logic signed [EXT_W-1:0] xe, ye, we, he, te, re, voe, sse, see, swe, rowe;
   logic signed [EXT_W-1:0] left_c, top_c, rw_c, rh_c;
   logic [rbsg_pkg::RSP_W-1:0] rect_c;

   // radius clamp
   always_comb begin
      half_c = ((w_ff < h_ff) ? w_ff : h_ff) >> 1;
      rlim_c = SIZE_W'(rq_ff);
      if (rlim_c > half_c) begin
         rlim_c = half_c;
      end
      if (rlim_c > SIZE_W'(rbsg_pkg::RADIUS_CAP)) begin
         rlim_c = SIZE_W'(rbsg_pkg::RADIUS_CAP);
      end
      r_in = rlim_c[R_W-1:0];
   end

   assign ri_c  = (BYTE_W'(r_ff) > t_ff) ? (r_ff - t_ff[R_W-1:0]) : '0;
   assign dr_c  = {r_ff, 1'b0};
   assign dri_c = {ri_c, 1'b0};
   assign d_c   = dr_c - {row_ff, 1'b0} - ROOT_W'(1);
   assign b_ok  = (d_c <= dri_c);

   assign r2_c   = SQ_W'(dr_c) * SQ_W'(dr_c);
   assign d2_c   = SQ_W'(d_c) * SQ_W'(d_c);
   assign i2_c   = SQ_W'(dri_c) * SQ_W'(dri_c);
   assign sq_val = cmd.sqrt_sel_b ? (i2_c - d2_c) : (r2_c - d2_c);

   rbsg_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.sqrt_start),
      .value (sq_val),
      .busy  (sq_busy),
      .root  (sq_root),
      .exact (sq_exact)
   );

   assign ca_sum = {1'b0, sq_root} + {{ROOT_W{1'b0}}, !sq_exact};

   // span extents of the current corner row
   always_comb begin
      rx_c = {2'b00, r_ff};
      ss_c = ({1'b0, dr_c} - {1'b0, ca_ff}) >> 1;
      if (b_ok) begin
         se_c = ({1'b0, dr_c} - {1'b0, fb_ff} + (ROOT_W+1)'(1)) >> 1;
      end else begin
         se_c = rx_c;
      end
      if (se_c > rx_c) begin
         se_c = rx_c;
      end
      if (se_c < ss_c) begin
         se_c = ss_c;
      end
   end

   // rectangle select
   assign xe   = {{(EXT_W-rbsg_pkg::COORD_W){x_ff[rbsg_pkg::COORD_W-1]}}, x_ff};
   assign ye   = {{(EXT_W-rbsg_pkg::COORD_W){y_ff[rbsg_pkg::COORD_W-1]}}, y_ff};
   assign we   = {{(EXT_W-SIZE_W){1'b0}}, w_ff};
   assign he   = {{(EXT_W-SIZE_W){1'b0}}, h_ff};
   assign te   = {{(EXT_W-BYTE_W){1'b0}}, t_ff};
   assign re   = {{(EXT_W-R_W){1'b0}}, r_ff};
   assign voe  = (r_ff == '0) ? te : re;
   assign sse  = {{(EXT_W-R_W){1'b0}}, ss_ff};
   assign see  = {{(EXT_W-R_W){1'b0}}, se_ff};
   assign swe  = {{(EXT_W-R_W){1'b0}}, sw_ff};
   assign rowe = {{(EXT_W-R_W){1'b0}}, row_ff};

   always_comb begin
      left_c = xe;
      top_c  = ye;
      rw_c   = swe;
      rh_c   = EXT_W'(1);
      if (cmd.push_span) begin
         left_c = part_ff[0] ? (xe + we - see) : (xe + sse);
         top_c  = part_ff[1] ? (ye + he - EXT_W'(1) - rowe) : (ye + rowe);
      end else begin
         case (part_ff)
            2'd0: begin
               left_c = xe + re;
               top_c  = ye;
               rw_c   = we - re - re;
               rh_c   = te;
            end
            2'd1: begin
               left_c = xe + re;
               top_c  = ye + he - te;
               rw_c   = we - re - re;
               rh_c   = te;
            end
            2'd2: begin
               left_c = xe;
               top_c  = ye + voe;
               rw_c   = te;
               rh_c   = he - voe - voe;
            end
            default: begin
               left_c = xe + we - te;
               top_c  = ye + voe;
               rw_c   = te;
               rh_c   = he - voe - voe;
            end
         endcase
      end
   end

   assign rect_c = {col_ff, rh_c[rbsg_pkg::RW_W-1:0], rw_c[rbsg_pkg::RW_W-1:0],
                    top_c[rbsg_pkg::LEFT_W-1:0], left_c[rbsg_pkg::LEFT_W-1:0]};

   // output staging
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_data_in   = out_data_ff;
      out_last_in   = out_last_ff;
      hold_valid_in = hold_valid_ff;
      hold_data_in  = hold_data_ff;
      if (cmd.push) begin
         if (hold_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = hold_data_ff;
            out_last_in  = 1'b0;
         end
         hold_valid_in = 1'b1;
         hold_data_in  = rect_c;
      end else if (cmd.flush && hold_valid_ff) begin
         out_valid_in  = 1'b1;
         out_data_in   = hold_data_ff;
         out_last_in   = 1'b1;
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         hold_valid_ff <= hold_valid_in;
      end
      out_data_ff  <= out_data_in;
      out_last_ff  <= out_last_in;
      hold_data_ff <= hold_data_in;
      if (cmd.load) begin
         x_ff   <= req_tdata[15:0];
         y_ff   <= req_tdata[31:16];
         w_ff   <= req_tdata[45:32];
         h_ff   <= req_tdata[59:46];
         t_ff   <= req_tdata[67:60];
         rq_ff  <= req_tdata[75:68];
         col_ff <= req_tdata[107:76];
      end
      if (cmd.clamp) begin
         r_ff <= r_in;
      end
      if (cmd.part_clr) begin
         part_ff <= '0;
      end else if (cmd.part_inc) begin
         part_ff <= part_ff + 2'd1;
      end
      if (cmd.row_clr) begin
         row_ff <= '0;
      end else if (cmd.row_inc) begin
         row_ff <= row_ff + R_W'(1);
      end
      if (cmd.latch_a) begin
         ca_ff <= ca_sum[ROOT_W-1:0];
      end
      if (cmd.latch_b) begin
         fb_ff <= sq_root;
      end
      if (cmd.span_calc) begin
         ss_ff <= ss_c[R_W-1:0];
         se_ff <= se_c[R_W-1:0];
         sw_ff <= se_c[R_W-1:0] - ss_c[R_W-1:0];
      end
   end

   always_comb begin
      status.degenerate = (w_ff == '0) || (h_ff == '0) || (t_ff == '0);
      status.r_zero     = (r_ff == '0);
      status.part_last  = (part_ff == 2'd3);
      status.edge_on    = (r_ff == '0) ||
                          (part_ff[1] ? (he > re + re) : (we > re + re));
      status.row_last   = (row_ff == r_ff - R_W'(1));
      status.span_empty = (sw_ff == '0);
      status.sqrt_busy  = sq_busy;
      status.push_ok    = !hold_valid_ff || out_free;
      status.out_free   = out_free;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== rtl/core/rounded_border_span_generator.sv =====
// Rounded border span generator.
// Slave stream req_*: one word per border box. Master stream rsp_*: a run of
// filled rectangles that draw the box's rounded border, tlast on the final one.
// A box with zero width, height or thickness produces no rectangles.
// The block works on one box at a time; req_tready is high only while idle.
// The edge rectangles come first; a zero radius box has only those. Then come
// the corner rows, at most 15 since the radius is capped at 15. Each corner
// row runs two bit-serial square roots on the shared root unit, one result
// bit per cycle, and that unit sets the per-row cost.
// Rectangles pass through a one-word hold stage and an output register, so
// the last rectangle can be flagged before the next box is taken.
// When rsp_tready is low the output word holds and generation pauses once the
// hold stage is full; no rectangle is dropped.
// Synchronous reset returns the controller to idle and empties the output.
module rounded_border_span_generator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // box_x, box_y, box_width, box_height, thickness, radius_request,
   // red_in, green_in, blue_in, alpha_in, zero pad
   input  logic [rbsg_pkg::REQ_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // rect_left, rect_top, rect_w, rect_h, red_out, green_out, blue_out, alpha_out
   output logic [rbsg_pkg::RSP_W-1:0]    rsp_tdata,
   output logic                          rsp_tlast
);

   rbsg_pkg::cmd_type    cmd;
   rbsg_pkg::status_type status;

   rbsg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rbsg_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/core/rbsg_checker.sv =====
`include "rounded_border_span_generator_macros.svh"

module rbsg_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [rbsg_pkg::RSP_W-1:0]    rsp_tdata,
   input logic                          rsp_tlast
);

   `RBSG_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_tvalid && req_tready, "not idle after reset")

   `RBSG_ASSERT_NEXT(a_accept_busy, clock, reset, req_tvalid && req_tready, !req_tready, "took two boxes back to back")

   `RBSG_ASSERT_IMPL(a_midbox_busy, clock, reset, rsp_tvalid && !rsp_tlast, !req_tready, "ready while box unfinished")

   `RBSG_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled word changed")

endmodule

bind rounded_border_span_generator rbsg_checker u_rbsg_checker (.*);
